@@ rtl/bimf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bimf_pkg
// Shared types, constants and the 3x3 mask decision for the binary
// impulse-noise mask filter.
// ----------------------------------------------------------------------------
package bimf_pkg;

    // payload and register widths
    localparam int PIX_W = 8;
    localparam int CFG_W = 12;
    localparam int ROW_W = 12;

    // defaults
    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_FRAME_WIDTH  = 640;
    localparam int DEF_FRAME_HEIGHT = 480;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [PIX_W-1:0] WHITE_VALUE = 8'd255;
    localparam logic [PIX_W-1:0] BLACK_VALUE = 8'd0;

    // register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // input op codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // control carried from front to back with each word
    typedef struct packed {
        logic emit;      // word produces a result
        logic interior;  // result pixel is judged by the mask
        logic last;      // result pixel closes the frame
    } bimf_ctl_t;

    // mask decision: nbr[k-1] is neighbour xk, x5 is the centre
    function automatic logic [PIX_W-1:0] bimf_judge(input logic [8:0] nbr,
                                                    input logic [PIX_W-1:0] centre);
        logic x1, x2, x3, x4, x5, x6, x7, x8, x9;
        logic [PIX_W-1:0] res;
        x1 = nbr[0]; x2 = nbr[1]; x3 = nbr[2];
        x4 = nbr[3]; x5 = nbr[4]; x6 = nbr[5];
        x7 = nbr[6]; x8 = nbr[7]; x9 = nbr[8];
        res = centre;
        if (x5) begin
            if ((!x6 && !x8 && (!x2 || !x4)) || (!x2 && !x4 && (!x6 || !x8))) begin
                res = BLACK_VALUE;
            end
        end else begin
            if ((x1 && x2 && x4 && ((x7 && x8) || (x3 && x6))) ||
                (x6 && x8 && x9 && ((x2 && x3) || (x4 && x7)))) begin
                res = WHITE_VALUE;
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/bimf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bimf_front
// Accepts words, holds the frame registers and all raster bookkeeping, and
// tags each kept word with its line column and result control.
// ----------------------------------------------------------------------------
module bimf_front import bimf_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int COL_W  = $clog2(MAX_WIDTH),
    localparam int W_W    = $clog2(MAX_WIDTH + 1),
    localparam int FILL_W = $clog2(MAX_WIDTH + 2)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             in_accept,
    input  logic             in_op,
    input  logic [PIX_W-1:0] in_pixel,
    output logic             push,
    output logic [COL_W-1:0] push_col,
    output logic [PIX_W-1:0] push_pix,
    output bimf_ctl_t        push_ctl
);

    localparam int RST_WIDTH = (DEF_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_FRAME_WIDTH;

    logic [W_W-1:0]   width_reg, width_next;
    logic [ROW_W-1:0] height_reg, height_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    logic [W_W-1:0]   in_col_inc, out_col_inc;
    logic [ROW_W-1:0] out_row_inc;
    logic             drop, emit, interior, last, flush;

    // classification of the incoming word
    always_comb begin
        flush       = (in_op == OP_FLUSH);
        drop        = flush && (fill_reg == '0);
        emit        = (fill_reg == (FILL_W'(width_reg) + 1'b1));
        in_col_inc  = W_W'(in_col_reg) + 1'b1;
        out_col_inc = W_W'(out_col_reg) + 1'b1;
        out_row_inc = out_row_reg + 1'b1;
        interior    = (out_row_reg != '0) && (out_row_inc < height_reg) &&
                      (out_col_reg != '0) && (out_col_inc < width_reg);
        last        = (out_row_inc >= height_reg) && (out_col_inc >= width_reg);
    end

    assign push              = in_accept && !drop;
    assign push_col          = in_col_reg;
    assign push_pix          = flush ? BLACK_VALUE : in_pixel;
    assign push_ctl.emit     = emit;
    assign push_ctl.interior = interior;
    assign push_ctl.last     = last;

    // raster position and register updates
    always_comb begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        fill_next    = fill_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_WIDTH: begin
                    if (cfg_wdata == '0) begin
                        width_next = W_W'(1);
                    end else if (int'(cfg_wdata) > MAX_WIDTH) begin
                        width_next = W_W'(MAX_WIDTH);
                    end else begin
                        width_next = W_W'(cfg_wdata);
                    end
                end
                REG_FRAME_HEIGHT: begin
                    height_next = (cfg_wdata == '0) ? ROW_W'(1) : ROW_W'(cfg_wdata);
                end
                default: ;
            endcase
            in_col_next  = '0;
            fill_next    = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (push) begin
            in_col_next = (in_col_inc >= width_reg) ? '0 : in_col_inc[COL_W-1:0];
            if (emit) begin
                if (out_col_inc >= width_reg) begin
                    out_col_next = '0;
                    out_row_next = (out_row_inc >= height_reg) ? '0 : out_row_inc;
                end else begin
                    out_col_next = out_col_inc[COL_W-1:0];
                end
                // flush that ends the frame empties the pipeline
                if (last && flush) begin
                    in_col_next  = '0;
                    fill_next    = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
            end else begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= W_W'(RST_WIDTH);
            height_reg  <= ROW_W'(DEF_FRAME_HEIGHT);
            in_col_reg  <= '0;
            fill_reg    <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            fill_reg    <= fill_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

@@ rtl/bimf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bimf_queue
// Short register queue between front and back so each side stalls alone.
// ----------------------------------------------------------------------------
module bimf_queue import bimf_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH,
    parameter int COL_W = $clog2(DEF_MAX_WIDTH),
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [COL_W-1:0] push_col,
    input  logic [PIX_W-1:0] push_pix,
    input  bimf_ctl_t        push_ctl,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output logic [COL_W-1:0] head_col,
    output logic [PIX_W-1:0] head_pix,
    output bimf_ctl_t        head_ctl
);

    logic [COL_W-1:0] col_q [DEPTH];
    logic [PIX_W-1:0] pix_q [DEPTH];
    bimf_ctl_t        ctl_q [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_col = col_q[rd_ptr_reg];
    assign head_pix = pix_q[rd_ptr_reg];
    assign head_ctl = ctl_q[rd_ptr_reg];

    // pointer and occupancy
    always_comb begin
        do_push     = push && !full;
        do_pop      = pop && !empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            col_q[wr_ptr_reg] <= push_col;
            pix_q[wr_ptr_reg] <= push_pix;
            ctl_q[wr_ptr_reg] <= push_ctl;
        end
    end

endmodule

@@ rtl/bimf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bimf_back
// Line store access, 3x3 window, mask decision and output register.
// ----------------------------------------------------------------------------
module bimf_back import bimf_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear,
    input  logic             q_empty,
    input  logic [COL_W-1:0] q_col,
    input  logic [PIX_W-1:0] q_pix,
    input  bimf_ctl_t        q_ctl,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_pixel_out,
    output logic             m_frame_last
);

    // line store: {row two above, row one above} per column
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;
    logic [2*PIX_W-1:0] byp_data_reg;
    logic               byp_reg;

    logic             b_vld_reg;
    logic [COL_W-1:0] b_col_reg;
    logic [PIX_W-1:0] b_pix_reg;
    bimf_ctl_t        b_ctl_reg;

    logic [2:0]       c1_reg, c2_reg;
    logic [PIX_W-1:0] ctr_reg;

    logic             m_valid_reg;
    logic [PIX_W-1:0] m_pixel_reg;
    logic             m_last_reg;

    logic               advance, retire;
    logic [2*PIX_W-1:0] lines;
    logic [PIX_W-1:0]   up, lo, res;
    logic [2:0]         new_col;
    logic [8:0]         nbr;

    assign advance = !m_valid_reg || m_ready;
    assign q_pop   = advance && !q_empty;
    assign retire  = advance && b_vld_reg;

    // line data, with the word just retired forwarded over the store
    always_comb begin
        lines   = byp_reg ? byp_data_reg : rd_reg;
        up      = lines[2*PIX_W-1:PIX_W];
        lo      = lines[PIX_W-1:0];
        new_col = {b_pix_reg != '0, lo != '0, up != '0};
        nbr     = {new_col[2], c2_reg[2], c1_reg[2],
                   new_col[1], c2_reg[1], c1_reg[1],
                   new_col[0], c2_reg[0], c1_reg[0]};
        res     = b_ctl_reg.interior ? bimf_judge(nbr, ctr_reg) : ctr_reg;
    end

    // line store read and write
    always_ff @(posedge aclk) begin
        if (retire) begin
            line_mem[b_col_reg] <= {lo, b_pix_reg};
        end
        if (q_pop) begin
            rd_reg       <= line_mem[q_col];
            byp_data_reg <= {lo, b_pix_reg};
        end
    end

    // working stage and forward flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
            byp_reg   <= 1'b0;
        end else if (advance) begin
            b_vld_reg <= q_pop;
            if (q_pop) begin
                byp_reg <= retire && (b_col_reg == q_col);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            b_col_reg <= q_col;
            b_pix_reg <= q_pix;
            b_ctl_reg <= q_ctl;
        end
    end

    // window columns shift by one per retired word
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            c1_reg  <= '0;
            c2_reg  <= '0;
            ctr_reg <= '0;
        end else if (retire) begin
            c1_reg  <= c2_reg;
            c2_reg  <= new_col;
            ctr_reg <= lo;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (retire && b_ctl_reg.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (retire && b_ctl_reg.emit) begin
            m_pixel_reg <= res;
            m_last_reg  <= b_ctl_reg.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = m_pixel_reg;
    assign m_frame_last = m_last_reg;

endmodule

@@ rtl/binary_impulse_noise_mask_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_impulse_noise_mask_filter
// Streaming 3x3 salt-and-pepper mask filter for 8-bit raster images.
// ----------------------------------------------------------------------------
// Takes one word per clock and gives one result per clock when the output is
// not stalled. The filtered pixel at raster position n leaves with the word at
// position n + width + 1; the first width + 1 words of a stream give no
// result, and flush words (op = 1) push out the tail of a frame, the one that
// carries the frame's last pixel emptying the pipeline. Inside the block a
// word passes front bookkeeping into a four-entry queue, a line-store read,
// then the mask decision into the output register. The line store is one
// 16-bit single-port-read RAM of MAX_WIDTH entries and needs no clearing
// after reset. A register write restarts the stream and must be made only
// while the block is idle; the block itself does not enforce this.
module binary_impulse_noise_mask_filter import bimf_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_op,
    input  logic [PIX_W-1:0] s_pixel_in,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_pixel_out,
    output logic             m_frame_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic             q_full, q_empty, push, pop;
    logic [COL_W-1:0] push_col, head_col;
    logic [PIX_W-1:0] push_pix, head_pix;
    bimf_ctl_t        push_ctl, head_ctl;

    assign s_ready = !q_full;

    // front: classify and tag
    bimf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_accept (s_valid && s_ready),
        .in_op     (s_op),
        .in_pixel  (s_pixel_in),
        .push      (push),
        .push_col  (push_col),
        .push_pix  (push_pix),
        .push_ctl  (push_ctl)
    );

    // decoupling queue
    bimf_queue #(.DEPTH(QUEUE_DEPTH), .COL_W(COL_W)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_col (push_col),
        .push_pix (push_pix),
        .push_ctl (push_ctl),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_col (head_col),
        .head_pix (head_pix),
        .head_ctl (head_ctl)
    );

    // back: line store, window, decision
    bimf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .clear        (cfg_wr_en),
        .q_empty      (q_empty),
        .q_col        (head_col),
        .q_pix        (head_pix),
        .q_ctl        (head_ctl),
        .q_pop        (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_frame_last (m_frame_last)
    );

endmodule

@@ rtl/bimf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bimf_checker
// Port-level checks on the mask filter: output hold, reset state and drain.
// ----------------------------------------------------------------------------
module bimf_checker import bimf_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [PIX_W-1:0] m_pixel_out,
    input logic             m_frame_last
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_out) && $stable(m_frame_last))
        else $error("result word changed while stalled");

    // empty and ready right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

    // a free output lets the queue drain, so input is ready next cycle
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |=> s_ready)
        else $error("input not ready although output was free");

endmodule

bind binary_impulse_noise_mask_filter bimf_checker u_bimf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_pixel_out  (m_pixel_out),
    .m_frame_last (m_frame_last)
);
